/* rtl/polygon_convexity_and_bounds_macros.svh */
// Assertion macros shared by the polygon convexity and bounds RTL.
`ifndef POLYGON_CONVEXITY_AND_BOUNDS_MACROS_SVH
`define POLYGON_CONVEXITY_AND_BOUNDS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCVX_ASSERT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("pcvx assertion failed");

// Next-cycle implication, disabled during reset.
`define PCVX_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("pcvx assertion failed");

`endif

/* rtl/pcvx_pkg.sv */
// Package: widths, turn-sign type and helpers for the polygon convexity block.
`timescale 1ns / 1ps
package pcvx_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // Sign of one cross product; both low means exactly zero.
  typedef struct packed {
    logic pos;
    logic neg;
  } turn_t;

  // Exact difference a - b, one bit wider than the coordinates.
  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    diff_t ea;
    diff_t eb;
    ea = {a[COORD_BITS-1], a};
    eb = {b[COORD_BITS-1], b};
    return ea - eb;
  endfunction

endpackage

/* rtl/pcvx_cross.sv */
// Cross product sign unit: registered products, then a signed compare.
`timescale 1ns / 1ps
module pcvx_cross (
  input  logic             clk,
  input  logic             en,
  input  pcvx_pkg::diff_t  ux,
  input  pcvx_pkg::diff_t  uy,
  input  pcvx_pkg::diff_t  wx,
  input  pcvx_pkg::diff_t  wy,
  output pcvx_pkg::turn_t  turn
);
  import pcvx_pkg::*;

  prod_t p_uxwy;
  prod_t p_uywx;

  always_ff @(posedge clk) begin
    if (en) begin
      p_uxwy <= prod_t'(ux) * prod_t'(wy);
      p_uywx <= prod_t'(uy) * prod_t'(wx);
    end
  end

  // ux*wy - uy*wx has the sign of the product comparison
  always_comb begin
    turn.pos = (p_uxwy > p_uywx);
    turn.neg = (p_uxwy < p_uywx);
  end

endmodule

/* rtl/polygon_convexity_and_bounds.sv */
// Polygon convexity and bounding box: vertex front end, turn pipeline, result register.
//
// Vertices of one closed polygon stream in on the input channel (vertex_x,
// vertex_y, last_vertex) in chain order, one transaction per vertex.
// A transaction completes on a rising edge with valid high and stall low.
// The vertex carrying last_vertex produces exactly one result transaction
// (is_convex and the four bounds); other vertices produce none. Polygons of
// one or two vertices, and polygons whose closing reference turn is zero,
// report convex.
// Throughput: one vertex per cycle while input stall is low. The three cross products of a vertex
// (pair turn, closing turn, reference turn) each use two 17x17 multipliers
// with a product register, so the path is difference -> multiply -> compare.
// The last vertex passes the stage-1 difference registers, then the product
// registers, then the result register.
// Reset (rst, synchronous) empties the pipeline, drops any held result and
// starts a new polygon. While a result waits under output stall the pipeline
// keeps moving until another last vertex would need the result register;
// only then is input stall raised.
`timescale 1ns / 1ps
module polygon_convexity_and_bounds (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pcvx_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [pcvx_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                   last_vertex,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   is_convex,
  output logic signed [pcvx_pkg::COORD_BITS-1:0] left_bound,
  output logic signed [pcvx_pkg::COORD_BITS-1:0] right_bound,
  output logic signed [pcvx_pkg::COORD_BITS-1:0] bottom_bound,
  output logic signed [pcvx_pkg::COORD_BITS-1:0] top_bound
);
  import pcvx_pkg::*;

  // front-end polygon state
  coord_t     first_vx, first_vy, second_vx, second_vy;
  coord_t     prev_vx, prev_vy, older_vx, older_vy;
  logic [1:0] vertices_seen;
  coord_t     min_x_so_far, max_x_so_far, min_y_so_far, max_y_so_far;
  coord_t     min_x_next, max_x_next, min_y_next, max_y_next;

  // stage 1: edge differences
  logic   s1_valid, s1_last, s1_pair_en;
  diff_t  s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy, s1_dx, s1_dy;
  coord_t s1_min_x, s1_max_x, s1_min_y, s1_max_y;

  // stage 2: products live in the cross units
  logic   s2_valid, s2_last, s2_pair_en;
  coord_t s2_min_x, s2_max_x, s2_min_y, s2_max_y;
  turn_t  pair_turn, close_turn, ref_turn;

  // stage 3: turn accumulation
  logic seen_positive_turn, seen_negative_turn;
  logic pos_next, neg_next, convex_next;

  logic adv;
  logic accept;

  assign adv      = !(out_valid && out_stall && s2_valid && s2_last);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    if (vertices_seen == 2'd0) begin
      min_x_next = vertex_x;
      max_x_next = vertex_x;
      min_y_next = vertex_y;
      max_y_next = vertex_y;
    end else begin
      min_x_next = (vertex_x < min_x_so_far) ? vertex_x : min_x_so_far;
      max_x_next = (vertex_x > max_x_so_far) ? vertex_x : max_x_so_far;
      min_y_next = (vertex_y < min_y_so_far) ? vertex_y : min_y_so_far;
      max_y_next = (vertex_y > max_y_so_far) ? vertex_y : max_y_so_far;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertices_seen <= 2'd0;
    end else if (accept) begin
      if (last_vertex) begin
        vertices_seen <= 2'd0;
      end else if (vertices_seen != 2'd3) begin
        vertices_seen <= vertices_seen + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (vertices_seen == 2'd0) begin
        first_vx <= vertex_x;
        first_vy <= vertex_y;
      end
      if (vertices_seen == 2'd1) begin
        second_vx <= vertex_x;
        second_vy <= vertex_y;
      end
      older_vx     <= prev_vx;
      older_vy     <= prev_vy;
      prev_vx      <= vertex_x;
      prev_vy      <= vertex_y;
      min_x_so_far <= min_x_next;
      max_x_so_far <= max_x_next;
      min_y_so_far <= min_y_next;
      max_y_so_far <= max_y_next;
    end
  end

  // a: incoming edge, b: edge to this vertex, c: closing edge, d: first edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last    <= last_vertex;
      s1_pair_en <= vertices_seen[1];
      s1_ax      <= coord_diff(prev_vx, older_vx);
      s1_ay      <= coord_diff(prev_vy, older_vy);
      s1_bx      <= coord_diff(vertex_x, prev_vx);
      s1_by      <= coord_diff(vertex_y, prev_vy);
      s1_cx      <= coord_diff(first_vx, vertex_x);
      s1_cy      <= coord_diff(first_vy, vertex_y);
      s1_dx      <= coord_diff(second_vx, first_vx);
      s1_dy      <= coord_diff(second_vy, first_vy);
      s1_min_x   <= min_x_next;
      s1_max_x   <= max_x_next;
      s1_min_y   <= min_y_next;
      s1_max_y   <= max_y_next;
    end
  end

  pcvx_cross u_pair_cross (
    .clk  (clk),
    .en   (adv),
    .ux   (s1_ax),
    .uy   (s1_ay),
    .wx   (s1_bx),
    .wy   (s1_by),
    .turn (pair_turn)
  );

  pcvx_cross u_close_cross (
    .clk  (clk),
    .en   (adv),
    .ux   (s1_bx),
    .uy   (s1_by),
    .wx   (s1_cx),
    .wy   (s1_cy),
    .turn (close_turn)
  );

  pcvx_cross u_ref_cross (
    .clk  (clk),
    .en   (adv),
    .ux   (s1_cx),
    .uy   (s1_cy),
    .wx   (s1_dx),
    .wy   (s1_dy),
    .turn (ref_turn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last    <= s1_last;
      s2_pair_en <= s1_pair_en;
      s2_min_x   <= s1_min_x;
      s2_max_x   <= s1_max_x;
      s2_min_y   <= s1_min_y;
      s2_max_y   <= s1_max_y;
    end
  end

  // closing turn only counts on the last vertex
  always_comb begin
    pos_next = seen_positive_turn
             | (s2_pair_en & pair_turn.pos)
             | (s2_pair_en & s2_last & close_turn.pos);
    neg_next = seen_negative_turn
             | (s2_pair_en & pair_turn.neg)
             | (s2_pair_en & s2_last & close_turn.neg);
    convex_next = !(s2_pair_en &&
                    ((ref_turn.pos && neg_next) || (ref_turn.neg && pos_next)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_positive_turn <= 1'b0;
      seen_negative_turn <= 1'b0;
    end else if (adv && s2_valid) begin
      seen_positive_turn <= pos_next && !s2_last;
      seen_negative_turn <= neg_next && !s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s2_valid && s2_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_last) begin
      is_convex    <= convex_next;
      left_bound   <= s2_min_x;
      right_bound  <= s2_max_x;
      bottom_bound <= s2_min_y;
      top_bound    <= s2_max_y;
    end
  end

`include "polygon_convexity_and_bounds_macros.svh"

  `PCVX_ASSERT(a_stall_only_on_full_result, clk, rst, in_stall, out_valid && out_stall && s2_valid && s2_last)
  `PCVX_ASSERT_NEXT(a_last_clears_count, clk, rst, in_valid && !in_stall && last_vertex, vertices_seen == 2'd0)
  `PCVX_ASSERT(a_bounds_ordered, clk, rst, out_valid, (left_bound <= right_bound) && (bottom_bound <= top_bound))
  `PCVX_ASSERT_NEXT(a_flags_clear_after_last, clk, rst, !in_stall && s2_valid && s2_last, !seen_positive_turn && !seen_negative_turn)

endmodule
